### hdl/cvms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Closest video mode select package
// Request and result payload types, register indexes and distance helpers.
// ----------------------------------------------------------------------------
package cvms_pkg;

    // Candidate mode request
    typedef struct packed {
        logic [4:0]  red_bits;
        logic [4:0]  green_bits;
        logic [4:0]  blue_bits;
        logic [13:0] mode_width;
        logic [13:0] mode_height;
        logic [9:0]  refresh_rate;
        logic        last_mode;
    } in_t;

    // Result of one mode list
    typedef struct packed {
        logic [7:0] best_index;
        logic [8:0] mode_count;
    } out_t;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_ADDR_W-1:0] REG_RED     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GREEN   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLUE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_REFRESH = 3'd5;

    // Target of -1 marks a channel or refresh rate as don't-care
    localparam logic [5:0]  COLOR_DONT_CARE = 6'h3F;
    localparam logic [10:0] RATE_DONT_CARE  = 11'h7FF;
    localparam logic [5:0]  COLOR_SAT       = 6'd63;

    localparam int COLOR_W = 6;
    localparam int SIZE_W  = 29;
    // Rate key: flag bit set when the target is don't-care (all-ones minus rate)
    localparam int RATE_W  = 13;

    // |depth - target| for one channel, zero when the target is don't-care
    function automatic logic [6:0] color_term(input logic [4:0] depth,
                                              input logic [5:0] target);
        logic [7:0] diff;
        logic [7:0] mag;
        diff = {3'b000, depth} - {{2{target[5]}}, target};
        mag  = diff[7] ? (8'd0 - diff) : diff;
        if (target == COLOR_DONT_CARE) begin
            return 7'd0;
        end
        return mag[6:0];
    endfunction

    // |a - b| of two unsigned 14-bit values
    function automatic logic [13:0] size_term(input logic [13:0] a,
                                              input logic [13:0] b);
        logic [14:0] diff;
        logic [14:0] mag;
        diff = {1'b0, a} - {1'b0, b};
        mag  = diff[14] ? (15'd0 - diff) : diff;
        return mag[13:0];
    endfunction

endpackage

### hdl/closest_video_mode_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Closest video mode select
// Streams candidate display modes and reports the index of the closest match
// to the configured target mode when the last mode of a list arrives.
// ----------------------------------------------------------------------------
// A last mode moves through the stage 1 and stage 2 registers into the result register.
// Throughput: one mode per cycle while no last mode is held back; the compare against
//   the held best fit feeds the best-fit registers, squarings sit one stage ahead of it.
// A result waiting at m_ stalls a following last mode and the modes behind it; earlier modes flow.
// Reset (aresetn low, synchronous): pipeline and list state cleared, targets
//   return to don't-care colour and refresh, zero width and height.
// ----------------------------------------------------------------------------
module closest_video_mode_select #(
    parameter int MAX_MODES = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_we,
    input  logic [cvms_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [cvms_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // mode requests
    input  logic                               s_valid,
    output logic                               s_ready,
    input  cvms_pkg::in_t                      s_data,
    // results
    output logic                               m_valid,
    input  logic                               m_ready,
    output cvms_pkg::out_t                     m_data
);

    localparam int CNT_W = $clog2(MAX_MODES + 1);
    localparam int POS_W = $clog2(MAX_MODES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MODES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [5:0]  cfg_red_reg, cfg_green_reg, cfg_blue_reg;
    logic [13:0] cfg_width_reg, cfg_height_reg;
    logic [10:0] cfg_refresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_red_reg     <= cvms_pkg::COLOR_DONT_CARE;
            cfg_green_reg   <= cvms_pkg::COLOR_DONT_CARE;
            cfg_blue_reg    <= cvms_pkg::COLOR_DONT_CARE;
            cfg_width_reg   <= '0;
            cfg_height_reg  <= '0;
            cfg_refresh_reg <= cvms_pkg::RATE_DONT_CARE;
        end else if (cfg_we) begin
            case (cfg_addr)
                cvms_pkg::REG_RED:     cfg_red_reg     <= cfg_wdata[5:0];
                cvms_pkg::REG_GREEN:   cfg_green_reg   <= cfg_wdata[5:0];
                cvms_pkg::REG_BLUE:    cfg_blue_reg    <= cfg_wdata[5:0];
                cvms_pkg::REG_WIDTH:   cfg_width_reg   <= cfg_wdata[13:0];
                cvms_pkg::REG_HEIGHT:  cfg_height_reg  <= cfg_wdata[13:0];
                cvms_pkg::REG_REFRESH: cfg_refresh_reg <= cfg_wdata[10:0];
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: each stage advances when the one after it is free.
    // Only a last mode needs the result register, so a waiting result
    // holds back a last mode and the modes queued behind it.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic s2_last_reg;
    logic out_free, fire3, s2_free, fire2, s1_free;

    assign out_free = !m_valid_reg || m_ready;
    assign fire3    = s2_valid_reg && (!s2_last_reg || out_free);
    assign s2_free  = !s2_valid_reg || fire3;
    assign fire2    = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || fire2;
    assign s_ready  = s1_free;

    // ------------------------------------------------------------------
    // Stage 1: request register
    // ------------------------------------------------------------------
    cvms_pkg::in_t s1_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_free) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s1_free) begin
            s1_data_reg <= s_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: distance keys (colour sum, squared size, rate key)
    // ------------------------------------------------------------------
    logic [6:0]  c_red, c_green, c_blue;
    logic [7:0]  c_sum;
    logic [cvms_pkg::COLOR_W-1:0] c_dist;
    logic [13:0] d_w, d_h;
    logic [27:0] sq_w, sq_h;
    logic [cvms_pkg::SIZE_W-1:0]  s_dist;
    logic [12:0] r_diff;
    logic [11:0] r_mag;
    logic [cvms_pkg::RATE_W-1:0]  r_key;

    always_comb begin
        c_red   = cvms_pkg::color_term(s1_data_reg.red_bits, cfg_red_reg);
        c_green = cvms_pkg::color_term(s1_data_reg.green_bits, cfg_green_reg);
        c_blue  = cvms_pkg::color_term(s1_data_reg.blue_bits, cfg_blue_reg);
        c_sum   = 8'(c_red) + 8'(c_green) + 8'(c_blue);
        // saturate at the key width
        c_dist  = (c_sum > 8'(cvms_pkg::COLOR_SAT)) ? cvms_pkg::COLOR_SAT : c_sum[5:0];

        d_w    = cvms_pkg::size_term(s1_data_reg.mode_width, cfg_width_reg);
        d_h    = cvms_pkg::size_term(s1_data_reg.mode_height, cfg_height_reg);
        sq_w   = 28'(d_w) * 28'(d_w);
        sq_h   = 28'(d_h) * 28'(d_h);
        s_dist = cvms_pkg::SIZE_W'(sq_w) + cvms_pkg::SIZE_W'(sq_h);

        r_diff = {3'b000, s1_data_reg.refresh_rate} - {{2{cfg_refresh_reg[10]}},
                                                        cfg_refresh_reg};
        r_mag  = r_diff[12] ? 12'(13'd0 - r_diff) : r_diff[11:0];
        // Don't-care target: all-ones minus rate keeps its order in 13 bits
        // and always ranks behind any plain difference.
        if (cfg_refresh_reg == cvms_pkg::RATE_DONT_CARE) begin
            r_key = {3'b111, ~s1_data_reg.refresh_rate};
        end else begin
            r_key = {1'b0, r_mag};
        end
    end

    logic [cvms_pkg::COLOR_W-1:0] s2_color_reg;
    logic [cvms_pkg::SIZE_W-1:0]  s2_size_reg;
    logic [cvms_pkg::RATE_W-1:0]  s2_rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_free) begin
            s2_valid_reg <= fire2;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire2) begin
            s2_color_reg <= c_dist;
            s2_size_reg  <= s_dist;
            s2_rate_reg  <= r_key;
            s2_last_reg  <= s1_data_reg.last_mode;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: compare against the held best fit, count, emit on last
    // ------------------------------------------------------------------
    logic                          have_best_reg, have_best_next;
    logic [cvms_pkg::COLOR_W-1:0]  best_color_reg, best_color_next;
    logic [cvms_pkg::SIZE_W-1:0]   best_size_reg, best_size_next;
    logic [cvms_pkg::RATE_W-1:0]   best_rate_reg, best_rate_next;
    logic [POS_W-1:0]              best_pos_reg, best_pos_next;
    logic [CNT_W-1:0]              seen_cnt_reg, seen_cnt_next;
    logic                          m_valid_next;
    cvms_pkg::out_t                m_data_reg, m_data_next;
    logic                          counted, better;
    logic [31:0]                   pos_wide, cnt_wide;

    always_comb begin
        have_best_next  = have_best_reg;
        best_color_next = best_color_reg;
        best_size_next  = best_size_reg;
        best_rate_next  = best_rate_reg;
        best_pos_next   = best_pos_reg;
        seen_cnt_next   = seen_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        counted = seen_cnt_reg < CNT_MAX;
        better  = !have_best_reg
               || (s2_color_reg < best_color_reg)
               || (s2_color_reg == best_color_reg && s2_size_reg < best_size_reg)
               || (s2_color_reg == best_color_reg && s2_size_reg == best_size_reg
                   && s2_rate_reg < best_rate_reg);

        if (fire3 && counted) begin
            // strict less-than: ties hold the earlier mode
            if (better) begin
                have_best_next  = 1'b1;
                best_color_next = s2_color_reg;
                best_size_next  = s2_size_reg;
                best_rate_next  = s2_rate_reg;
                best_pos_next   = seen_cnt_reg[POS_W-1:0];
            end
            seen_cnt_next = seen_cnt_reg + CNT_W'(1);
        end

        pos_wide = 32'(best_pos_next);
        cnt_wide = 32'(seen_cnt_next);

        if (fire3 && s2_last_reg) begin
            m_valid_next           = 1'b1;
            m_data_next.best_index = pos_wide[7:0];
            m_data_next.mode_count = cnt_wide[8:0];
            // clear list state for the next list
            have_best_next = 1'b0;
            best_pos_next  = '0;
            seen_cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg <= 1'b0;
            best_pos_reg  <= '0;
            seen_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            have_best_reg <= have_best_next;
            best_pos_reg  <= best_pos_next;
            seen_cnt_reg  <= seen_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_color_reg <= best_color_next;
        best_size_reg  <= best_size_next;
        best_rate_reg  <= best_rate_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a new result only follows a last mode leaving the compare stage
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s2_valid_reg && s2_last_reg))
        else $error("result appeared without a last mode");

    // mode counter saturates at MAX_MODES
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_cnt_reg <= CNT_MAX)
        else $error("mode counter passed MAX_MODES");

    // a held best fit exists exactly when the list has counted modes
    a_best_tracks_count: assert property (@(posedge aclk) disable iff (!aresetn)
        have_best_reg == (seen_cnt_reg != '0))
        else $error("best fit flag out of step with mode count");

    // held best position lies inside the counted part of the list
    a_pos_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        have_best_reg |-> (CNT_W'(best_pos_reg) < seen_cnt_reg))
        else $error("best position beyond mode count");

endmodule
